### rtl/core/fts_pkg.sv
// Shared types, constants and codes for the FIR-then-smoother block.
`timescale 1ns / 1ps
package fts_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int MAX_TAPS_DEF = 4;

    localparam int CH_W     = 4;
    localparam int SAMPLE_W = 16;
    localparam int OUT_W    = 24;
    localparam int WEIGHT_W = 17;
    localparam int TAPS_W   = 3;
    localparam int COEF_W   = 16;
    localparam int NUM_COEFS = 4;
    localparam int COEF_IW  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'd65536;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 17'd49152;
    localparam logic [TAPS_W-1:0]   TAPS_RST   = 3'd1;
    localparam logic [COEF_W-1:0]   COEF0_RST  = 16'd16384;
    localparam logic [COEF_W-1:0]   COEFN_RST  = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT = 3'd0,
        REG_TAPS   = 3'd1,
        REG_COEF0  = 3'd2,
        REG_COEF1  = 3'd3,
        REG_COEF2  = 3'd4,
        REG_COEF3  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [CH_W-1:0]         out_channel;
        logic signed [OUT_W-1:0] smoothed;
    } result_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0]                  weight;
        logic [TAPS_W-1:0]                    taps_used;
        logic [NUM_COEFS-1:0][COEF_W-1:0]     coef;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic chan_upd;
        logic hist_rd;
        logic mac;
        logic blend_mul;
        logic blend_sum;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ch_ok;
        logic full;
        logic last_tap;
        logic out_free;
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHAN,
        S_HREAD,
        S_HACC,
        S_BL1,
        S_BL2,
        S_OUT
    } state_t;

endpackage

### rtl/core/fts_cfg.sv
// Configuration register bank: weight, window length and coefficients.
`timescale 1ns / 1ps
module fts_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fts_pkg::CFG_DATA_W-1:0]    cfg_data,
    output fts_pkg::cfg_t                     cfg
);

    fts_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.weight    <= fts_pkg::WEIGHT_RST;
            cfg_reg.taps_used <= fts_pkg::TAPS_RST;
            cfg_reg.coef[0]   <= fts_pkg::COEF0_RST;
            cfg_reg.coef[1]   <= fts_pkg::COEFN_RST;
            cfg_reg.coef[2]   <= fts_pkg::COEFN_RST;
            cfg_reg.coef[3]   <= fts_pkg::COEFN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fts_pkg::REG_WEIGHT: cfg_reg.weight    <= cfg_data;
                fts_pkg::REG_TAPS:   cfg_reg.taps_used <= cfg_data[fts_pkg::TAPS_W-1:0];
                fts_pkg::REG_COEF0:  cfg_reg.coef[0]   <= cfg_data[fts_pkg::COEF_W-1:0];
                fts_pkg::REG_COEF1:  cfg_reg.coef[1]   <= cfg_data[fts_pkg::COEF_W-1:0];
                fts_pkg::REG_COEF2:  cfg_reg.coef[2]   <= cfg_data[fts_pkg::COEF_W-1:0];
                fts_pkg::REG_COEF3:  cfg_reg.coef[3]   <= cfg_data[fts_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

### rtl/core/fts_ctrl.sv
// Controller state machine that sequences one transaction through the datapath.
`timescale 1ns / 1ps
module fts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  fts_pkg::status_t  status,
    output fts_pkg::cmd_t     cmd
);

    fts_pkg::state_t state_reg;
    fts_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            fts_pkg::S_IDLE:
            begin
                item_ready = 1'b1;
                // A transaction for a channel out of range is taken and dropped.
                if (item_valid && status.ch_ok)
                begin
                    cmd.load   = 1'b1;
                    state_next = fts_pkg::S_CHAN;
                end
            end
            fts_pkg::S_CHAN:
            begin
                cmd.chan_upd = 1'b1;
                state_next   = status.full ? fts_pkg::S_HREAD : fts_pkg::S_IDLE;
            end
            fts_pkg::S_HREAD:
            begin
                cmd.hist_rd = 1'b1;
                state_next  = fts_pkg::S_HACC;
            end
            fts_pkg::S_HACC:
            begin
                cmd.mac    = 1'b1;
                state_next = status.last_tap ? fts_pkg::S_BL1 : fts_pkg::S_HREAD;
            end
            fts_pkg::S_BL1:
            begin
                cmd.blend_mul = 1'b1;
                state_next    = fts_pkg::S_BL2;
            end
            fts_pkg::S_BL2:
            begin
                cmd.blend_sum = 1'b1;
                state_next    = fts_pkg::S_OUT;
            end
            fts_pkg::S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = fts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fts_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/fts_dp.sv
// Datapath: per-channel state, sample history, tap accumulator, blend and output register.
`timescale 1ns / 1ps
module fts_dp #(
    parameter int CHANNELS = fts_pkg::CHANNELS_DEF,
    parameter int MAX_TAPS = fts_pkg::MAX_TAPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fts_pkg::item_t     item,
    input  fts_pkg::cfg_t      cfg,
    input  fts_pkg::cmd_t      cmd,
    output fts_pkg::status_t   status,
    output logic               result_valid,
    input  logic               result_ready,
    output fts_pkg::result_t   result
);

    localparam int CHW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int HDEPTH = CHANNELS * MAX_TAPS;
    localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int TW     = fts_pkg::TAPS_W;
    localparam int IW     = HW + TW + 1;
    localparam int TAP_CAP = (MAX_TAPS < 7) ? MAX_TAPS : 7;
    localparam int SW     = fts_pkg::SAMPLE_W;
    localparam int OW     = fts_pkg::OUT_W;
    localparam int WW     = fts_pkg::WEIGHT_W;
    localparam int PROD_W = 2 * SW;
    localparam int ACC_W  = PROD_W + TW;
    localparam int P1_W   = ACC_W + WW + 1;
    localparam int P2_W   = OW + WW + 1;
    localparam int SUM_W  = P2_W + 15;
    localparam int R_W    = SUM_W - 30;

    localparam logic signed [SUM_W-1:0] RND_HALF = {{(SUM_W-30){1'b0}}, 1'b1, 29'b0};
    localparam logic signed [R_W-1:0]   R_MAX = R_W'(8388607);
    localparam logic signed [R_W-1:0]   R_MIN = -R_W'(8388608);

    // Per-channel state memories, one shared address, plus a valid bit per channel.
    logic [TW-1:0]        fill_mem [CHANNELS];
    logic [HW-1:0]        head_mem [CHANNELS];
    logic signed [OW-1:0] last_mem [CHANNELS];
    logic [CHANNELS-1:0]  chan_vld_reg;

    logic signed [SW-1:0] hist_mem [HDEPTH];

    logic [CHW-1:0]                 ch_reg;
    logic [fts_pkg::CH_W-1:0]       chin_reg;
    logic signed [SW-1:0]           samp_reg;
    logic                           rd_vld_reg;
    logic [TW-1:0]                  rd_fill_reg;
    logic [HW-1:0]                  rd_head_reg;
    logic signed [OW-1:0]           rd_last_reg;
    logic [TW-1:0]                  fill_reg;
    logic [HW-1:0]                  head_reg;
    logic signed [OW-1:0]           last_reg;
    logic [TW-1:0]                  k_reg;
    logic signed [SW-1:0]           hist_rd_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [P1_W-1:0]         p1_reg;
    logic signed [SUM_W-1:0]        sum_reg;
    logic                           out_valid_reg;
    fts_pkg::result_t               out_reg;

    logic [TW-1:0]        taps;
    logic [TW-1:0]        fill_cur;
    logic [HW-1:0]        head_cur;
    logic signed [OW-1:0] last_cur;
    logic [TW:0]          fill_inc;
    logic [TW-1:0]        fill_next;
    logic [HW-1:0]        head_next;
    logic [IW-1:0]        head_w;
    logic [IW-1:0]        k_w;
    logic [IW-1:0]        slot_w;
    logic [HW-1:0]        slot;
    logic [HAW-1:0]       hist_wr_addr;
    logic [HAW-1:0]       hist_rd_addr;
    logic signed [SW-1:0]   coef_sel;
    logic signed [PROD_W-1:0] prod;
    logic [WW-1:0]        w_clamp;
    logic [WW-1:0]        w_comp;
    logic signed [P2_W-1:0] p2;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [R_W-1:0]  r_wide;
    logic signed [OW-1:0]   r_sat;
    logic                   chan_we;
    logic [TW-1:0]          chan_wr_fill;
    logic [HW-1:0]          chan_wr_head;
    logic signed [OW-1:0]   chan_wr_last;

    // Window length in effect: zero acts as one, anything above the depth as the depth.
    always_comb
    begin
        if (cfg.taps_used == '0)
            taps = TW'(1);
        else if (int'(cfg.taps_used) > TAP_CAP)
            taps = TW'(TAP_CAP);
        else
            taps = cfg.taps_used;
    end

    // A channel never written since reset starts empty with a zero last output.
    assign fill_cur = rd_vld_reg ? rd_fill_reg : '0;
    assign head_cur = rd_vld_reg ? rd_head_reg : '0;
    assign last_cur = rd_vld_reg ? rd_last_reg : '0;

    assign fill_inc  = {1'b0, fill_cur} + (TW+1)'(1);
    assign fill_next = (fill_inc > {1'b0, taps}) ? taps : fill_inc[TW-1:0];
    assign head_next = (head_cur == HW'(MAX_TAPS - 1)) ? '0 : head_cur + HW'(1);

    // History is a ring per channel; the k-th newest sample sits k slots behind the head.
    always_comb
    begin
        head_w = IW'(head_reg);
        k_w    = IW'(k_reg);
        if (head_w >= k_w)
            slot_w = head_w - k_w;
        else
            slot_w = head_w + IW'(MAX_TAPS) - k_w;
    end
    assign slot = slot_w[HW-1:0];

    assign hist_wr_addr = HAW'(ch_reg) * HAW'(MAX_TAPS) + HAW'(head_next);
    assign hist_rd_addr = HAW'(ch_reg) * HAW'(MAX_TAPS) + HAW'(slot);

    always_comb
    begin
        if (int'(k_reg) < fts_pkg::NUM_COEFS)
            coef_sel = $signed(cfg.coef[k_reg[fts_pkg::COEF_IW-1:0]]);
        else
            coef_sel = '0;
    end
    assign prod = hist_rd_reg * coef_sel;

    assign w_clamp = (cfg.weight > fts_pkg::ONE_Q16) ? fts_pkg::ONE_Q16 : cfg.weight;
    assign w_comp  = fts_pkg::ONE_Q16 - w_clamp;

    assign p2       = last_reg * $signed({1'b0, w_comp});
    assign sum_next = SUM_W'(p1_reg) + (SUM_W'(p2) <<< 14) + RND_HALF;

    // Arithmetic shift by 30 floors, then clip to the 24-bit output range.
    assign r_wide = sum_reg[SUM_W-1:30];
    always_comb
    begin
        if (r_wide > R_MAX)
            r_sat = R_MAX[OW-1:0];
        else if (r_wide < R_MIN)
            r_sat = R_MIN[OW-1:0];
        else
            r_sat = r_wide[OW-1:0];
    end

    assign chan_we      = cmd.chan_upd || cmd.emit;
    assign chan_wr_fill = cmd.emit ? fill_reg : fill_next;
    assign chan_wr_head = cmd.emit ? head_reg : head_next;
    assign chan_wr_last = cmd.emit ? r_sat : last_cur;

    assign status.ch_ok    = int'(item.channel) < CHANNELS;
    assign status.full     = (fill_next == taps);
    assign status.last_tap = ({1'b0, k_reg} + (TW+1)'(1)) == {1'b0, taps};
    assign status.out_free = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk)
    begin
        if (chan_we)
        begin
            fill_mem[ch_reg] <= chan_wr_fill;
            head_mem[ch_reg] <= chan_wr_head;
            last_mem[ch_reg] <= chan_wr_last;
        end
        if (cmd.load)
        begin
            rd_fill_reg <= fill_mem[CHW'(item.channel)];
            rd_head_reg <= head_mem[CHW'(item.channel)];
            rd_last_reg <= last_mem[CHW'(item.channel)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.chan_upd)
            hist_mem[hist_wr_addr] <= samp_reg;
        if (cmd.hist_rd)
            hist_rd_reg <= hist_mem[hist_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg   <= CHW'(item.channel);
            chin_reg <= item.channel;
            samp_reg <= item.sample;
        end
        if (cmd.chan_upd)
        begin
            fill_reg <= fill_next;
            head_reg <= head_next;
            last_reg <= last_cur;
            k_reg    <= '0;
            acc_reg  <= '0;
        end
        if (cmd.mac)
        begin
            acc_reg <= acc_reg + ACC_W'(prod);
            k_reg   <= k_reg + TW'(1);
        end
        if (cmd.blend_mul)
            p1_reg <= acc_reg * $signed({1'b0, w_clamp});
        if (cmd.blend_sum)
            sum_reg <= sum_next;
        if (cmd.emit)
        begin
            out_reg.out_channel <= chin_reg;
            out_reg.smoothed    <= r_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_vld_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (chan_we)
                chan_vld_reg[ch_reg] <= 1'b1;
            if (cmd.load)
                rd_vld_reg <= chan_vld_reg[CHW'(item.channel)];
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

### rtl/core/fir_then_exponential_smoother.sv
// Top level of the per-channel FIR filter followed by an exponential smoother.
`timescale 1ns / 1ps
// Each transaction on the item channel carries a channel number and a signed sample; the
// block keeps the last taps_used samples of each channel, forms their dot product with the
// Q2.14 coefficients, blends it with the channel's previous output by the Q1.16 weight and
// returns the rounded, 24-bit saturated value on the result channel. Items are handled one
// at a time: a channel at or above CHANNELS is taken in the idle state and gives no result,
// an item that leaves the window short passes only through the channel update state, and
// an item with a full window also runs the tap loop, which reads the single-port history
// memory and runs one multiply-accumulate per tap, followed by the two blend multiplies;
// a result that is not taken holds the controller in its output state until the output
// register frees up. Per-channel fill counts and last outputs read as zero after reset
// through a valid bit per channel, so no clearing pass is needed.
module fir_then_exponential_smoother #(
    parameter int CHANNELS = fts_pkg::CHANNELS_DEF,
    parameter int MAX_TAPS = fts_pkg::MAX_TAPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  fts_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output fts_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fts_pkg::CFG_DATA_W-1:0]    cfg_data
);

    fts_pkg::cfg_t    cfg;
    fts_pkg::cmd_t    cmd;
    fts_pkg::status_t status;

    fts_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fts_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    fts_dp #(
        .CHANNELS (CHANNELS),
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### verif/fir_then_exponential_smoother_test.sv
// Self-checking testbench for the per-channel FIR filter and exponential smoother.
`timescale 1ns / 1ps
module fir_then_exponential_smoother_test;

    localparam int CHANNELS = fts_pkg::CHANNELS_DEF;
    localparam int MAX_TAPS = fts_pkg::MAX_TAPS_DEF;
    localparam int IDX_W = fts_pkg::CFG_IDX_W;
    localparam int CHAN_W = fts_pkg::CH_W;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam longint CYCLE_LIMIT = 300000;
    localparam longint HALF_Q30 = longint'(1) << 29;
    localparam longint SAT_HI = 8388607;
    localparam longint SAT_LO = -8388608;
    localparam logic [fts_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [fts_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    fts_pkg::item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    fts_pkg::result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [fts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [fts_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    fir_then_exponential_smoother DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // Shadow copy of the block's configuration and per-channel state.
    logic [fts_pkg::WEIGHT_W-1:0] cfg_weight;
    logic [fts_pkg::TAPS_W-1:0] cfg_taps;
    logic signed [fts_pkg::COEF_W-1:0] cfg_coef [fts_pkg::NUM_COEFS];
    logic signed [fts_pkg::SAMPLE_W-1:0] window [CHANNELS][MAX_TAPS];
    int fill_cnt [CHANNELS];
    logic signed [fts_pkg::OUT_W-1:0] last_out [CHANNELS];

    fts_pkg::item_t pending [$];
    fts_pkg::result_t smoothed_due [$];
    int queued_total = 0;
    int accepted_total = 0;
    int fail_count = 0;
    int results_seen = 0;
    longint cycle_count = 0;

    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int pattern_left = 0;
    logic [31:0] ready_bits = '1;
    fts_pkg::result_t due;
    fts_pkg::result_t want;

    function automatic void apply_reg(input logic [fts_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [fts_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            fts_pkg::REG_WEIGHT: cfg_weight = data[fts_pkg::WEIGHT_W-1:0];
            fts_pkg::REG_TAPS:   cfg_taps = data[fts_pkg::TAPS_W-1:0];
            fts_pkg::REG_COEF0:  cfg_coef[0] = data[fts_pkg::COEF_W-1:0];
            fts_pkg::REG_COEF1:  cfg_coef[1] = data[fts_pkg::COEF_W-1:0];
            fts_pkg::REG_COEF2:  cfg_coef[2] = data[fts_pkg::COEF_W-1:0];
            fts_pkg::REG_COEF3:  cfg_coef[3] = data[fts_pkg::COEF_W-1:0];
            default: ;
        endcase
    endfunction

    // Shifts the sample into its channel's window and, once the window is full,
    // returns the filtered value blended with the channel's previous output.
    function automatic bit fir_smooth_step(input fts_pkg::item_t it,
                                           output fts_pkg::result_t res);
        int ch;
        int taps_eff;
        int fill;
        longint acc;
        longint w_eff;
        longint blend;
        longint rounded;
        res = '0;
        ch = int'(it.channel);
        if (ch >= CHANNELS)
            return 1'b0;
        for (int k = MAX_TAPS - 1; k > 0; k--)
            window[ch][k] = window[ch][k - 1];
        window[ch][0] = it.sample;
        taps_eff = (cfg_taps == 0) ? 1 : (int'(cfg_taps) > MAX_TAPS) ? MAX_TAPS : int'(cfg_taps);
        fill = fill_cnt[ch] + 1;
        if (fill > taps_eff)
            fill = taps_eff;
        fill_cnt[ch] = fill;
        if (fill != taps_eff)
            return 1'b0;
        acc = 0;
        for (int k = 0; k < taps_eff; k++)
            if (k < fts_pkg::NUM_COEFS)
                acc += longint'(window[ch][k]) * longint'(cfg_coef[k]);
        w_eff = (cfg_weight > fts_pkg::ONE_Q16) ? 65536 : cfg_weight;
        blend = acc * w_eff + longint'(last_out[ch]) * (65536 - w_eff) * 16384;
        rounded = (blend + HALF_Q30) >>> 30;
        if (rounded > SAT_HI)
            rounded = SAT_HI;
        if (rounded < SAT_LO)
            rounded = SAT_LO;
        last_out[ch] = rounded[fts_pkg::OUT_W-1:0];
        res.out_channel = it.channel;
        res.smoothed = rounded[fts_pkg::OUT_W-1:0];
        return 1'b1;
    endfunction

    function automatic void offer(input int ch, input logic signed [fts_pkg::SAMPLE_W-1:0] s);
        fts_pkg::item_t it;
        it.channel = CHAN_W'(ch);
        it.sample = s;
        pending.push_back(it);
        queued_total++;
    endfunction

    function automatic logic signed [fts_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 2) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [fts_pkg::COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh4000;
            3: return 16'shC000;
            4: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Leaves cfg_valid high so that back-to-back writes never lower and raise it
    // in one step; the caller drops it after the last write.
    task automatic write_reg(input logic [fts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fts_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, data);
    endtask

    task automatic wait_idle();
        while (accepted_total != queued_total || smoothed_due.size() != 0)
            @(posedge clk);
        // Items that leave a window short give no result but may still be in flight.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk) begin
        if (rst_n) begin
            if (item_valid && item_ready) begin
                if (fir_smooth_step(item, due))
                    smoothed_due.push_back(due);
                accepted_total++;
            end
            if (!item_valid || item_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pending.size() != 0) begin
                    item <= pending.pop_front();
                    item_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result transaction and stalls on a rotating pattern.
    always @(posedge clk) begin
        if (!rst_n)
            result_ready <= 1'b0;
        else begin
            if (result_valid && result_ready) begin
                if (smoothed_due.size() == 0) begin
                    $error("unexpected result: out_channel %0d, smoothed %0d",
                           result.out_channel, result.smoothed);
                    fail_count++;
                end
                else begin
                    want = smoothed_due.pop_front();
                    if (result.out_channel !== want.out_channel) begin
                        $error("out_channel mismatch: expected %0d, actual %0d",
                               want.out_channel, result.out_channel);
                        fail_count++;
                    end
                    if (result.smoothed !== want.smoothed) begin
                        $error("smoothed mismatch: expected %0d, actual %0d",
                               want.smoothed, result.smoothed);
                        fail_count++;
                    end
                end
                results_seen++;
                // A long hold-off lets the block back up and stall its input.
                if (results_seen % 250 == 40)
                    hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else begin
                if (pattern_left == 0) begin
                    case ($urandom_range(0, 3))
                        0: ready_bits = '1;
                        1: ready_bits = $urandom;
                        2: ready_bits = $urandom | $urandom;
                        default: ready_bits = $urandom & $urandom;
                    endcase
                    pattern_left = 32;
                end
                result_ready <= ready_bits[0];
                ready_bits = {ready_bits[0], ready_bits[31:1]};
                pattern_left--;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [fts_pkg::CFG_DATA_W-1:0] wdata;
        logic [fts_pkg::CFG_DATA_W-1:0] tdata;
        bit narrow;

        cfg_weight = fts_pkg::WEIGHT_RST;
        cfg_taps = fts_pkg::TAPS_RST;
        cfg_coef[0] = fts_pkg::COEF0_RST;
        for (int k = 1; k < fts_pkg::NUM_COEFS; k++)
            cfg_coef[k] = fts_pkg::COEFN_RST;
        for (int c = 0; c < CHANNELS; c++) begin
            fill_cnt[c] = 0;
            last_out[c] = '0;
            for (int k = 0; k < MAX_TAPS; k++)
                window[c][k] = '0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Settings after reset: one tap at unity gain, weight of three quarters.
        offer(0, 16'sh7FFF);
        offer(0, 16'sh8000);
        offer(15, -16'sd1);
        offer(15, 16'sd0);
        offer(5, 16'sh5555);
        offer(10, 16'shAAAA);

        // Full-scale coefficients of alternating sign on four taps, with the weight
        // and tap count written above their valid ranges.
        wait_idle();
        write_reg(fts_pkg::REG_WEIGHT, 17'h1FFFF);
        write_reg(fts_pkg::REG_TAPS, 17'h1FFFF);
        write_reg(fts_pkg::REG_COEF0, {1'b1, 16'h8000});
        write_reg(fts_pkg::REG_COEF1, {1'b0, 16'h7FFF});
        write_reg(fts_pkg::REG_COEF2, {1'b1, 16'h8000});
        write_reg(fts_pkg::REG_COEF3, {1'b1, 16'h7FFF});
        write_reg(REG_SPARE_B, 17'h1FFFF);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 6; i++)
            offer(15, (i % 2 == 0) ? 16'sh7FFF : 16'sh8000);
        for (int i = 0; i < 4; i++)
            offer(0, 16'sh8000);

        // Zero weight holds the previous output; a tap count of zero acts as one.
        wait_idle();
        write_reg(fts_pkg::REG_WEIGHT, 17'd0);
        write_reg(fts_pkg::REG_TAPS, 17'd0);
        write_reg(fts_pkg::REG_COEF0, {1'b0, 16'h7FFF});
        write_reg(REG_SPARE_A, 17'h0AAAA);
        cfg_valid <= 1'b0;
        offer(15, 16'sd0);
        offer(15, 16'sh7FFF);
        offer(0, 16'sh8000);
        offer(3, 16'sh1234);
        offer(0, 16'sd1);
        offer(7, 16'shFFFF);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            if (p == 0 || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 4))
                    0: wdata = 17'd0;
                    1: wdata = fts_pkg::ONE_Q16;
                    2: wdata = 17'($urandom);
                    default: wdata = 17'($urandom_range(0, 65536));
                endcase
                write_reg(fts_pkg::REG_WEIGHT, wdata);
            end
            tdata = 17'($urandom);
            if (p == 0)
                tdata[fts_pkg::TAPS_W-1:0] = 3'd1;
            else if (p == 1)
                tdata[fts_pkg::TAPS_W-1:0] = 3'd4;
            write_reg(fts_pkg::REG_TAPS, tdata);
            for (int k = 0; k < fts_pkg::NUM_COEFS; k++)
                if ($urandom_range(0, 3) != 0)
                    write_reg(IDX_W'(fts_pkg::REG_COEF0 + k), {1'($urandom), pick_coef()});
            if ($urandom_range(0, 2) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                          17'($urandom));
            cfg_valid <= 1'b0;
            // Some phases crowd a few channels so their windows refill often.
            narrow = ($urandom_range(0, 2) == 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                offer(narrow ? $urandom_range(0, 2) : $urandom_range(0, CHANNELS - 1),
                      pick_sample());
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (smoothed_due.size() != 0) begin
            $error("%0d expected results never arrived", smoothed_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### fir_then_exponential_smoother.f
rtl/core/fts_pkg.sv
rtl/core/fts_cfg.sv
rtl/core/fts_ctrl.sv
rtl/core/fts_dp.sv
rtl/core/fir_then_exponential_smoother.sv
verif/fir_then_exponential_smoother_test.sv
